// ===== sv/tcw_pkg.sv =====
package tcw_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;
    localparam int TAB_STEP        = 4;

    localparam logic [7:0] BLANK_CHAR  = 8'h20;
    localparam logic [7:0] RESET_ATTR  = 8'h07;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_RETURN   = 8'h0D;

    localparam int CELL_W = 16;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

endpackage

// ===== sv/tcw_ram.sv =====
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/text_console_writer.sv =====
// A put that does not scroll, and an unused code, give their result straight from the idle state;
// a read passes through the read state while the screen memory is read.
// A put that scrolls and a clear both sweep through the screen memory with a read-modify-write
// pass over its separate read and write ports before their result is given.
// After reset the block fills the screen with blanks in attribute 7 before it takes its first
// beat; configuration writes are taken throughout.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int ROWS    = ROWS_DEFAULT,
    localparam int CELLS  = COLUMNS * ROWS,
    localparam int ADDR_W = $clog2(CELLS)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_operation,
    input  logic [7:0]        s_character,
    input  logic [ADDR_W-1:0] s_cell_index,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ADDR_W-1:0] m_cursor,
    output logic [7:0]        m_read_char,
    output logic [7:0]        m_read_attr,
    output logic              m_scrolled
);

    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int CUR_W = $clog2(CELLS + TAB_STEP);
    localparam int COL_W = $clog2(COLUMNS + TAB_STEP);

    localparam logic [CNT_W-1:0] CELLS_CNT  = CNT_W'(CELLS);
    localparam logic [CNT_W-1:0] SCROLL_END = CNT_W'(CELLS - COLUMNS);
    localparam logic [CNT_W-1:0] COLS_CNT   = CNT_W'(COLUMNS);
    localparam logic [CUR_W-1:0] CELLS_CUR  = CUR_W'(CELLS);
    localparam logic [CUR_W-1:0] COLS_CUR   = CUR_W'(COLUMNS);
    localparam logic [CUR_W-1:0] TAB_CUR    = CUR_W'(TAB_STEP);
    localparam logic [COL_W-1:0] COLS_COL   = COL_W'(COLUMNS);
    localparam logic [COL_W-1:0] TAB_COL    = COL_W'(TAB_STEP);

    typedef enum logic [4:0] {
        ST_INIT   = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_READ   = 5'b00100,
        ST_CLEAR  = 5'b01000,
        ST_SCROLL = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CUR_W-1:0]  cursor_reg, cursor_next;
    logic [CUR_W-1:0]  base_reg, base_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [7:0]        attr_reg;
    logic              rd_ok_reg, rd_ok_next;
    logic              m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0] m_cursor_reg, m_cursor_next;
    logic [7:0]        m_read_char_reg, m_read_char_next;
    logic [7:0]        m_read_attr_reg, m_read_attr_next;
    logic              m_scrolled_reg, m_scrolled_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    logic [CUR_W-1:0]  put_cur, put_base, put_cur_fix, put_base_fix;
    logic [COL_W-1:0]  put_col;
    logic              put_write, put_wrap;
    logic [COL_W-1:0]  col_inc, col_tab;
    logic [CNT_W-1:0]  cnt_m1, cnt_src;
    logic              out_free, accept;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Cursor step for a put, tracked as row start plus column so that no remainder is needed.
    always_comb begin
        col_inc   = col_reg + COL_W'(1);
        col_tab   = col_reg + TAB_COL;
        put_cur   = cursor_reg;
        put_base  = base_reg;
        put_col   = col_reg;
        put_write = 1'b0;
        priority if (s_character == CH_NEWLINE) begin
            put_cur  = base_reg + COLS_CUR;
            put_base = base_reg + COLS_CUR;
            put_col  = '0;
        end else if (s_character == CH_RETURN) begin
            put_cur = base_reg;
            put_col = '0;
        end else if (s_character == CH_TAB) begin
            put_cur = cursor_reg + TAB_CUR;
            if (col_tab >= COLS_COL) begin
                put_col  = col_tab - COLS_COL;
                put_base = base_reg + COLS_CUR;
            end else begin
                put_col = col_tab;
            end
        end else begin
            put_write = 1'b1;
            put_cur   = cursor_reg + CUR_W'(1);
            if (col_inc == COLS_COL) begin
                put_col  = '0;
                put_base = base_reg + COLS_CUR;
            end else begin
                put_col = col_inc;
            end
        end
        put_wrap     = (put_cur >= CELLS_CUR);
        put_cur_fix  = put_wrap ? put_cur - COLS_CUR : put_cur;
        put_base_fix = put_wrap ? put_base - COLS_CUR : put_base;
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign cnt_src  = cnt_reg + COLS_CNT;

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        cursor_next      = cursor_reg;
        base_next        = base_reg;
        col_next         = col_reg;
        rd_ok_next       = rd_ok_reg;
        m_valid_next     = m_valid_reg;
        m_cursor_next    = m_cursor_reg;
        m_read_char_next = m_read_char_reg;
        m_read_attr_next = m_read_attr_reg;
        m_scrolled_next  = m_scrolled_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_raddr        = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[ADDR_W-1:0];
                ram_wdata = {RESET_ATTR, BLANK_CHAR};
                if (cnt_reg == CELLS_CNT - CNT_W'(1)) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_IDLE: begin
                ram_raddr = s_cell_index;
                if (accept) begin
                    m_read_char_next = '0;
                    m_read_attr_next = '0;
                    m_scrolled_next  = 1'b0;
                    unique case (s_operation)
                        OP_PUT: begin
                            ram_we      = put_write;
                            ram_waddr   = cursor_reg[ADDR_W-1:0];
                            ram_wdata   = {attr_reg, s_character};
                            cursor_next = put_cur_fix;
                            base_next   = put_base_fix;
                            col_next    = put_col;
                            if (put_wrap) begin
                                cnt_next   = '0;
                                state_next = ST_SCROLL;
                            end else begin
                                m_valid_next  = 1'b1;
                                m_cursor_next = put_cur_fix[ADDR_W-1:0];
                            end
                        end
                        OP_READ: begin
                            rd_ok_next = (CNT_W'(s_cell_index) < CELLS_CNT);
                            state_next = ST_READ;
                        end
                        OP_CLEAR: begin
                            cursor_next = '0;
                            base_next   = '0;
                            col_next    = '0;
                            cnt_next    = '0;
                            state_next  = ST_CLEAR;
                        end
                        default: begin
                            m_valid_next  = 1'b1;
                            m_cursor_next = cursor_reg[ADDR_W-1:0];
                        end
                    endcase
                end
            end
            ST_READ: begin
                m_valid_next     = 1'b1;
                m_cursor_next    = cursor_reg[ADDR_W-1:0];
                m_read_char_next = rd_ok_reg ? ram_rdata[7:0] : 8'h00;
                m_read_attr_next = rd_ok_reg ? ram_rdata[15:8] : 8'h00;
                state_next       = ST_IDLE;
            end
            ST_CLEAR: begin
                if (cnt_reg < CELLS_CNT) begin
                    ram_raddr = cnt_reg[ADDR_W-1:0];
                end
                if (cnt_reg != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_m1[ADDR_W-1:0];
                    ram_wdata = {ram_rdata[15:8], BLANK_CHAR};
                end
                if (cnt_reg == CELLS_CNT) begin
                    m_valid_next  = 1'b1;
                    m_cursor_next = cursor_reg[ADDR_W-1:0];
                    state_next    = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_SCROLL: begin
                if (cnt_reg < SCROLL_END) begin
                    ram_raddr = cnt_src[ADDR_W-1:0];
                end
                if (cnt_reg != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_m1[ADDR_W-1:0];
                    ram_wdata = (cnt_reg <= SCROLL_END) ? ram_rdata : {attr_reg, BLANK_CHAR};
                end
                if (cnt_reg == CELLS_CNT) begin
                    m_valid_next    = 1'b1;
                    m_cursor_next   = cursor_reg[ADDR_W-1:0];
                    m_scrolled_next = 1'b1;
                    state_next      = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default: begin
                state_next = ST_INIT;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            cnt_reg     <= '0;
            cursor_reg  <= '0;
            base_reg    <= '0;
            col_reg     <= '0;
            attr_reg    <= RESET_ATTR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cursor_reg  <= cursor_next;
            base_reg    <= base_next;
            col_reg     <= col_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                attr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_ok_reg       <= rd_ok_next;
        m_cursor_reg    <= m_cursor_next;
        m_read_char_reg <= m_read_char_next;
        m_read_attr_reg <= m_read_attr_next;
        m_scrolled_reg  <= m_scrolled_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_cursor    = m_cursor_reg;
    assign m_read_char = m_read_char_reg;
    assign m_read_attr = m_read_attr_reg;
    assign m_scrolled  = m_scrolled_reg;

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int COLUMNS     = COLUMNS_DEFAULT;
    localparam int ROWS        = ROWS_DEFAULT;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 235;
    localparam int HOLD_CYCLES = 300;
    localparam int REPORT_MAX  = 10;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] cursor;
        logic [7:0]        read_char;
        logic [7:0]        read_attr;
        logic              scrolled;
    } console_result_t;

    class screen_tracker;
        logic [15:0]     cells [CELLS];
        int unsigned     cursor_pos;
        logic [7:0]      attribute;
        console_result_t awaited [$];
        int              mismatches;
        int              results_checked;
        int              puts;
        int              reads;
        int              clears;
        int              scrolls;

        function new();
            for (int i = 0; i < CELLS; i++) begin
                cells[i] = {RESET_ATTR, BLANK_CHAR};
            end
            cursor_pos = 0;
            attribute = RESET_ATTR;
        endfunction

        function void note_command(logic [1:0] op, logic [7:0] ch, logic [ADDR_W-1:0] idx);
            console_result_t r;
            r = '0;
            if (op == OP_PUT) begin
                puts++;
                if (ch == CH_NEWLINE) begin
                    cursor_pos = cursor_pos + COLUMNS;
                    cursor_pos = cursor_pos - cursor_pos % COLUMNS;
                end else if (ch == CH_RETURN) begin
                    cursor_pos = cursor_pos - cursor_pos % COLUMNS;
                end else if (ch == CH_TAB) begin
                    cursor_pos = cursor_pos + TAB_STEP;
                end else begin
                    if (cursor_pos < CELLS) begin
                        cells[cursor_pos] = {attribute, ch};
                    end
                    cursor_pos++;
                end
                if (cursor_pos >= CELLS) begin
                    for (int i = 0; i < CELLS - COLUMNS; i++) begin
                        cells[i] = cells[i + COLUMNS];
                    end
                    for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
                        cells[i] = {attribute, BLANK_CHAR};
                    end
                    cursor_pos = cursor_pos - COLUMNS;
                    r.scrolled = 1'b1;
                    scrolls++;
                end
            end else if (op == OP_READ) begin
                reads++;
                if (idx < CELLS) begin
                    r.read_char = cells[idx][7:0];
                    r.read_attr = cells[idx][15:8];
                end
            end else if (op == OP_CLEAR) begin
                clears++;
                for (int i = 0; i < CELLS; i++) begin
                    cells[i][7:0] = BLANK_CHAR;
                end
                cursor_pos = 0;
            end
            r.cursor = cursor_pos[ADDR_W-1:0];
            awaited.push_back(r);
        endfunction

        function void check_result(console_result_t got);
            console_result_t want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("Unexpected result beat: cursor %0d char %02h attr %02h",
                             got.cursor, got.read_char, got.read_attr);
                end
                return;
            end
            want = awaited.pop_front();
            results_checked++;
            if (got.cursor !== want.cursor || got.read_char !== want.read_char ||
                got.read_attr !== want.read_attr || got.scrolled !== want.scrolled) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("Result %0d wrong, expected/actual: cursor %0d/%0d, char %02h/%02h,",
                             results_checked, want.cursor, got.cursor,
                             want.read_char, got.read_char);
                    $display("    attr %02h/%02h, scrolled %0b/%0b",
                             want.read_attr, got.read_attr, want.scrolled, got.scrolled);
                end
            end
        endfunction
    endclass

    logic              aclk         = 1'b0;
    logic              aresetn      = 1'b0;
    logic              cfg_we       = 1'b0;
    logic [7:0]        cfg_wdata    = 8'h00;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic [1:0]        s_operation  = 2'd0;
    logic [7:0]        s_character  = 8'h00;
    logic [ADDR_W-1:0] s_cell_index = '0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic [ADDR_W-1:0] m_cursor;
    logic [7:0]        m_read_char;
    logic [7:0]        m_read_attr;
    logic              m_scrolled;

    screen_tracker tracker;
    int  beats_sent;
    int  commands_counted;
    int  attribute_writes;
    int  sender_idle_pct;
    int  receiver_stall_pct;
    int  hold_left;
    bit  hold_wanted;

    text_console_writer dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_character  (s_character),
        .s_cell_index (s_cell_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cursor     (m_cursor),
        .m_read_char  (m_read_char),
        .m_read_attr  (m_read_attr),
        .m_scrolled   (m_scrolled)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic logic [7:0] random_glyph();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while (c == CH_TAB || c == CH_NEWLINE || c == CH_RETURN);
        return c;
    endfunction

    function automatic logic [ADDR_W-1:0] random_index();
        return ADDR_W'($urandom_range((1 << ADDR_W) - 1));
    endfunction

    // Many reads land just behind the cursor, where the latest text sits; the rest pick random indices.
    function automatic logic [ADDR_W-1:0] read_target();
        int unsigned pos;
        pos = tracker.cursor_pos;
        if (chance(20)) begin
            return random_index();
        end else if (chance(40)) begin
            return ADDR_W'($urandom_range(CELLS - 1));
        end else if (pos >= 2 * COLUMNS) begin
            return ADDR_W'(pos - $urandom_range(1, 2 * COLUMNS));
        end
        return ADDR_W'($urandom_range(2 * COLUMNS));
    endfunction

    always @(posedge aclk) begin
        if (hold_wanted) begin
            hold_left = HOLD_CYCLES;
            hold_wanted = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !chance(receiver_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                tracker.note_command(s_operation, s_character, s_cell_index);
            end
            if (m_valid && m_ready) begin
                tracker.check_result({m_cursor, m_read_char, m_read_attr, m_scrolled});
            end
        end
    end

    task automatic send_command(input logic [1:0] op, input logic [7:0] ch,
                                input logic [ADDR_W-1:0] idx);
        while (chance(sender_idle_pct)) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_character  <= ch;
        s_cell_index <= idx;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        beats_sent++;
        if (op != OP_UNUSED) begin
            commands_counted++;
        end
    endtask

    task automatic put_char(input logic [7:0] ch);
        send_command(OP_PUT, ch, random_index());
    endtask

    task automatic read_cell(input logic [ADDR_W-1:0] idx);
        send_command(OP_READ, 8'($urandom_range(255)), idx);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (tracker.results_checked < beats_sent) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_attribute(input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        tracker.attribute = value;
        attribute_writes++;
        @(posedge aclk);
    endtask

    task automatic random_burst();
        int kind;
        int n;
        int ending;
        kind = $urandom_range(99);
        if (kind < 55) begin
            n = chance(80) ? $urandom_range(40) : $urandom_range(40, 100);
            repeat (n) put_char(random_glyph());
            ending = $urandom_range(9);
            if (ending < 7) begin
                put_char(CH_NEWLINE);
            end else if (ending < 8) begin
                put_char(CH_RETURN);
            end else if (ending < 9) begin
                put_char(CH_TAB);
            end
        end else if (kind < 80) begin
            n = $urandom_range(1, 8);
            repeat (n) read_cell(read_target());
        end else if (kind < 90) begin
            n = $urandom_range(1, 24);
            repeat (n) begin
                put_char(chance(75) ? CH_TAB : random_glyph());
            end
        end else if (kind < 93) begin
            send_command(OP_CLEAR, 8'($urandom_range(255)), random_index());
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                send_command(2'($urandom_range(3)), 8'($urandom_range(255)), random_index());
            end
        end
    endtask

    initial begin
        int leftover;
        tracker = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        read_cell('0);
        read_cell(ADDR_W'(CELLS - 1));
        read_cell(ADDR_W'(CELLS));
        read_cell('1);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h41);
        put_char(CH_TAB);
        put_char(CH_NEWLINE);
        put_char(CH_RETURN);
        put_char(8'h7E);
        send_command(OP_UNUSED, 8'hFF, '1);
        read_cell('0);
        read_cell(ADDR_W'(1));
        read_cell(ADDR_W'(2));
        read_cell(ADDR_W'(COLUMNS));
        send_command(OP_CLEAR, 8'h00, '0);
        read_cell('0);
        read_cell(ADDR_W'(COLUMNS));
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 53;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 53;
                end
                default: begin
                    sender_idle_pct = 13;
                    receiver_stall_pct = 13;
                end
            endcase
            if (p == 0) begin
                write_attribute(8'h00);
            end else if (p == 1) begin
                write_attribute(8'hFF);
            end else if (p == 2) begin
                write_attribute(RESET_ATTR);
            end else begin
                write_attribute(8'($urandom_range(255)));
            end
            if (p == 1) begin
                hold_wanted = 1'b1;
                repeat (40) put_char(random_glyph());
            end
            while (commands_counted < p * PHASE_ITEMS + PHASE_ITEMS / 2) begin
                random_burst();
            end
            wait_drained();
            while (commands_counted < (p + 1) * PHASE_ITEMS) begin
                random_burst();
            end
            wait_drained();
        end

        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        repeat (CELLS + 16) @(posedge aclk);
        leftover = tracker.awaited.size();
        if (leftover != 0) begin
            $display("%0d expected results never arrived", leftover);
        end
        $display("Run covered %0d beats: %0d puts with %0d scrolls, %0d reads, %0d clears.",
                 beats_sent, tracker.puts, tracker.scrolls, tracker.reads, tracker.clears);
        $display("Attribute register written %0d times; %0d mismatches seen.",
                 attribute_writes, tracker.mismatches);
        if (tracker.mismatches == 0 && leftover == 0) begin
            $display("PASS text_console_writer");
        end else begin
            $display("FAIL text_console_writer");
        end
        $finish;
    end

    initial begin
        #500ms;
        $display("FAIL text_console_writer");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/text_console_writer.sv
verif/tb_top.sv
